// ===== rtl/tga_image_stream_decoder_assert.svh =====
// Assertion macros for the targa stream decoder checker.
// Needs a clock and an active-high reset passed in by the user.
`ifndef TGA_IMAGE_STREAM_DECODER_ASSERT_SVH
`define TGA_IMAGE_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, masked while reset is high.
`define TGA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked while reset is high.
`define TGA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is also checked across reset.
`define TGA_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/tgadec_pkg.sv =====
// Shared types and codes of the targa stream decoder.
// No dependencies; used by the top level and its checker.
package tgadec_pkg;

   // result kinds
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_PIXEL  = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   // error codes
   localparam logic [1:0] ERR_UNKNOWN     = 2'd0;
   localparam logic [1:0] ERR_NO_DATA     = 2'd1;
   localparam logic [1:0] ERR_UNSUPPORTED = 2'd2;
   localparam logic [1:0] ERR_READ        = 2'd3;

   // header byte positions
   localparam logic [4:0] HDR_ID_LEN    = 5'd0;
   localparam logic [4:0] HDR_CMAP      = 5'd1;
   localparam logic [4:0] HDR_TYPE      = 5'd2;
   localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
   localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
   localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
   localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
   localparam logic [4:0] HDR_DEPTH     = 5'd16;
   localparam logic [4:0] HDR_LAST      = 5'd17;

   // image types
   localparam logic [7:0] TYPE_NONE     = 8'd0;
   localparam logic [7:0] TYPE_CMAP     = 8'd1;
   localparam logic [7:0] TYPE_TRUE     = 8'd2;
   localparam logic [7:0] TYPE_GRAY     = 8'd3;
   localparam logic [7:0] TYPE_RLE_CMAP = 8'd9;
   localparam logic [7:0] TYPE_RLE_TRUE = 8'd10;
   localparam logic [7:0] TYPE_RLE_GRAY = 8'd11;

   localparam logic [7:0] DEPTH_24    = 8'd24;
   localparam logic [7:0] DEPTH_32    = 8'd32;
   localparam logic [7:0] REPEAT_BIAS = 8'd127;
   localparam logic [7:0] RUN_MAX     = 8'd128;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] pixel;
      logic [7:0]  run_length;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic        four_byte_pixels;
      logic        line_end;
      logic        image_end;
      logic [1:0]  error_code;
   } rsp_type;

endpackage

// ===== rtl/tga_image_stream_decoder.sv =====
// Targa stream decoder: header parse, id skip, raw and run-length pixel decode.
// Depends on tgadec_pkg.
//
// Usage:
//   Input channel req_*: one file byte per beat (req_data_byte), or an end of
//   file marker (req_stream_end high, byte ignored). The byte after a marker
//   starts a new file.
//   Result channel rsp_*: zero or one result per input beat: a header result
//   with width, height and depth, a pixel run (pixel plus run_length, with
//   line_end and image_end), or an error with error_code.
//   A result is registered and shows on rsp_valid in the cycle after the beat
//   that causes it. Throughput: one byte per cycle while no result is stalled,
//   set by the single state update per byte and the one-deep result register.
//   Stall: while a result sits unaccepted, req_ready is low; it rises again in
//   the cycle rsp_ready takes the result, so the block accepts a new byte in
//   the same cycle that the waiting result leaves.
//   Reset: synchronous, active high; clears the decode control state to the
//   start of a file and empties the result register; header bytes are not reset.
module tga_image_stream_decoder
   import tgadec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_stream_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_pixel,
   output logic [7:0]  rsp_run_length,
   output logic [15:0] rsp_image_width,
   output logic [15:0] rsp_image_height,
   output logic        rsp_four_byte_pixels,
   output logic        rsp_line_end,
   output logic        rsp_image_end,
   output logic [1:0]  rsp_error_code
);

   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_SKIP   = 2'd1;
   localparam logic [1:0] PH_PIXELS = 2'd2;
   localparam logic [1:0] PH_HALT   = 2'd3;

   logic [1:0]  phase_ff, phase_in;
   logic [4:0]  hdr_idx_ff, hdr_idx_in;
   logic [7:0]  id_len_ff, id_len_in;
   logic        cmap_bad_ff, cmap_bad_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  depth_ff, depth_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic        is_rle_ff, is_rle_in;
   logic        depth32_ff, depth32_in;
   logic [7:0]  skip_ff, skip_in;
   logic [15:0] left_ff, left_in;
   logic [15:0] row_ff, row_in;
   logic [7:0]  rep_ff, rep_in;
   logic [7:0]  raw_ff, raw_in;
   logic [1:0]  bip_ff, bip_in;
   logic [31:0] gather_ff, gather_in;

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        accept;
   logic        res_hit;
   rsp_type     res;

   logic [31:0] gather_or;
   logic        pixel_done;
   logic [7:0]  run;
   logic [15:0] left_after;
   logic [15:0] row_plus;
   logic        known_type;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign gather_or  = gather_ff | ({24'd0, req_data_byte} << {bip_ff, 3'b000});
   assign pixel_done = (bip_ff == (depth32_ff ? 2'd3 : 2'd2));
   assign run        = (rep_ff == 8'd0) ? 8'd1 :
                       (({8'd0, rep_ff} < left_ff) ? rep_ff : left_ff[7:0]);
   assign left_after = left_ff - {8'd0, run};
   assign row_plus   = row_ff + 16'd1;
   assign known_type = type_ff inside {TYPE_CMAP, TYPE_TRUE, TYPE_GRAY,
                                       TYPE_RLE_CMAP, TYPE_RLE_TRUE, TYPE_RLE_GRAY};

   always_comb begin
      phase_in    = phase_ff;
      hdr_idx_in  = hdr_idx_ff;
      id_len_in   = id_len_ff;
      cmap_bad_in = cmap_bad_ff;
      type_in     = type_ff;
      depth_in    = depth_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      is_rle_in   = is_rle_ff;
      depth32_in  = depth32_ff;
      skip_in     = skip_ff;
      left_in     = left_ff;
      row_in      = row_ff;
      rep_in      = rep_ff;
      raw_in      = raw_ff;
      bip_in      = bip_ff;
      gather_in   = gather_ff;
      res_hit     = 1'b0;
      res         = '0;

      if (accept && req_stream_end) begin
         // end of file: report a cut-short file, then restart
         res_hit        = (phase_ff != PH_HALT);
         res.kind       = KIND_ERROR;
         res.error_code = ERR_READ;
         phase_in       = PH_HEADER;
         hdr_idx_in     = 5'd0;
         is_rle_in      = 1'b0;
         depth32_in     = 1'b0;
         skip_in        = 8'd0;
         left_in        = 16'd0;
         row_in         = 16'd0;
         rep_in         = 8'd0;
         raw_in         = 8'd0;
         bip_in         = 2'd0;
         gather_in      = 32'd0;
      end else if (accept) begin
         unique case (phase_ff)
            PH_HEADER: begin
               unique case (hdr_idx_ff)
                  HDR_ID_LEN:    id_len_in = req_data_byte;
                  HDR_CMAP:      cmap_bad_in = (req_data_byte > 8'd1);
                  HDR_TYPE:      type_in = req_data_byte;
                  HDR_WIDTH_LO:  width_in[7:0] = req_data_byte;
                  HDR_WIDTH_HI:  width_in[15:8] = req_data_byte;
                  HDR_HEIGHT_LO: height_in[7:0] = req_data_byte;
                  HDR_HEIGHT_HI: height_in[15:8] = req_data_byte;
                  HDR_DEPTH:     depth_in = req_data_byte;
                  default: ;
               endcase
               hdr_idx_in = hdr_idx_ff + 5'd1;
               if (hdr_idx_ff == HDR_LAST) begin
                  res_hit  = 1'b1;
                  phase_in = PH_HALT;
                  res.kind = KIND_ERROR;
                  // checks run in file order; first failure wins
                  if (cmap_bad_ff) begin
                     res.error_code = ERR_UNKNOWN;
                  end else if (type_ff == TYPE_NONE) begin
                     res.error_code = ERR_NO_DATA;
                  end else if (!known_type) begin
                     res.error_code = ERR_UNKNOWN;
                  end else if ((type_ff != TYPE_TRUE && type_ff != TYPE_RLE_TRUE) ||
                               (depth_ff != DEPTH_24 && depth_ff != DEPTH_32)) begin
                     res.error_code = ERR_UNSUPPORTED;
                  end else begin
                     is_rle_in            = (type_ff == TYPE_RLE_TRUE);
                     depth32_in           = (depth_ff == DEPTH_32);
                     left_in              = width_ff;
                     res.kind             = KIND_HEADER;
                     res.image_width      = width_ff;
                     res.image_height     = height_ff;
                     res.four_byte_pixels = (depth_ff == DEPTH_32);
                     if (width_ff == 16'd0 || height_ff == 16'd0) begin
                        res.image_end = 1'b1;
                     end else if (id_len_ff != 8'd0) begin
                        skip_in  = id_len_ff;
                        phase_in = PH_SKIP;
                     end else begin
                        phase_in = PH_PIXELS;
                     end
                  end
               end
            end
            PH_SKIP: begin
               skip_in = skip_ff - 8'd1;
               if (skip_ff == 8'd1) begin
                  phase_in = PH_PIXELS;
               end
            end
            PH_PIXELS: begin
               if (is_rle_ff && rep_ff == 8'd0 && raw_ff == 8'd0) begin
                  // packet head
                  if (req_data_byte >= RUN_MAX) begin
                     rep_in = req_data_byte - REPEAT_BIAS;
                  end else begin
                     raw_in = req_data_byte + 8'd1;
                  end
               end else if (!pixel_done) begin
                  gather_in = gather_or;
                  bip_in    = bip_ff + 2'd1;
               end else begin
                  res_hit        = 1'b1;
                  res.kind       = KIND_PIXEL;
                  res.pixel      = gather_or;
                  res.run_length = run;
                  gather_in      = 32'd0;
                  bip_in         = 2'd0;
                  left_in        = left_after;
                  if (rep_ff != 8'd0) begin
                     rep_in = 8'd0;
                  end else if (raw_ff != 8'd0) begin
                     raw_in = raw_ff - 8'd1;
                  end
                  if (left_after == 16'd0) begin
                     // line end: clear packet state and move to the next row
                     left_in      = width_ff;
                     rep_in       = 8'd0;
                     raw_in       = 8'd0;
                     row_in       = row_plus;
                     res.line_end = 1'b1;
                     if (row_plus == height_ff) begin
                        res.image_end = 1'b1;
                        phase_in      = PH_HALT;
                     end
                  end
               end
            end
            PH_HALT: ;
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (accept && res_hit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         hdr_idx_ff   <= 5'd0;
         is_rle_ff    <= 1'b0;
         depth32_ff   <= 1'b0;
         skip_ff      <= 8'd0;
         left_ff      <= 16'd0;
         row_ff       <= 16'd0;
         rep_ff       <= 8'd0;
         raw_ff       <= 8'd0;
         bip_ff       <= 2'd0;
         gather_ff    <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         hdr_idx_ff   <= hdr_idx_in;
         is_rle_ff    <= is_rle_in;
         depth32_ff   <= depth32_in;
         skip_ff      <= skip_in;
         left_ff      <= left_in;
         row_ff       <= row_in;
         rep_ff       <= rep_in;
         raw_ff       <= raw_in;
         bip_ff       <= bip_in;
         gather_ff    <= gather_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // header bytes and result payload: written before use, no reset
   always_ff @(posedge clock) begin
      id_len_ff   <= id_len_in;
      cmap_bad_ff <= cmap_bad_in;
      type_ff     <= type_in;
      depth_ff    <= depth_in;
      width_ff    <= width_in;
      height_ff   <= height_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_kind             = rsp_ff.kind;
   assign rsp_pixel            = rsp_ff.pixel;
   assign rsp_run_length       = rsp_ff.run_length;
   assign rsp_image_width      = rsp_ff.image_width;
   assign rsp_image_height     = rsp_ff.image_height;
   assign rsp_four_byte_pixels = rsp_ff.four_byte_pixels;
   assign rsp_line_end         = rsp_ff.line_end;
   assign rsp_image_end        = rsp_ff.image_end;
   assign rsp_error_code       = rsp_ff.error_code;

endmodule

// ===== rtl/tgadec_checker.sv =====
// Port-level checks for the targa stream decoder, bound to the top level.
// Depends on tgadec_pkg and tga_image_stream_decoder_assert.svh.
`include "tga_image_stream_decoder_assert.svh"

module tgadec_checker
   import tgadec_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [31:0] rsp_pixel,
   input logic [7:0]  rsp_run_length,
   input logic        rsp_line_end,
   input logic        rsp_image_end
);

   // reset empties the result register
   `TGA_ASSERT_ALWAYS_NEXT(a_reset_empty, clock, reset, !rsp_valid, "result after reset")

   // a stalled result beat holds
   `TGA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_kind) && $stable(rsp_pixel) && $stable(rsp_run_length),
      "stalled result changed")

   // a full, stalled result register blocks the input side
   `TGA_ASSERT_NOW(a_backpressure, clock, reset, rsp_valid && !rsp_ready, !req_ready,
      "input taken while result stalled")

   // pixel runs carry one to the maximum packet length of copies
   `TGA_ASSERT_NOW(a_run_range, clock, reset, rsp_valid && rsp_kind == KIND_PIXEL,
      rsp_run_length != 8'd0 && rsp_run_length <= RUN_MAX, "run length out of range")

   // errors never claim a line or image end and carry a zero pixel
   `TGA_ASSERT_NOW(a_error_flags, clock, reset, rsp_valid && rsp_kind == KIND_ERROR,
      !rsp_line_end && !rsp_image_end && rsp_pixel == 32'd0, "error with pixel flags")

endmodule

bind tga_image_stream_decoder tgadec_checker u_tgadec_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_kind       (rsp_kind),
   .rsp_pixel      (rsp_pixel),
   .rsp_run_length (rsp_run_length),
   .rsp_line_end   (rsp_line_end),
   .rsp_image_end  (rsp_image_end)
);
